### design/mlh_pkg.sv
// ----------------------------------------------------------------------------
// mlh_pkg: shared types and constants of the max line hull engine
// Field widths, status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlh_pkg;

   localparam int MAX_LINES_DEF = 64;
   localparam int SLOPE_W       = 32;
   localparam int ICPT_W        = 63;
   localparam int X_W           = 32;
   localparam int VAL_W         = 64;
   localparam int LINE_W        = SLOPE_W + ICPT_W;
   localparam int REQ_DATA_W    = 128;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_REDUNDANT = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } mlh_status_type;

   typedef enum logic [1:0] {
      CTX_INS,
      CTX_RIGHT,
      CTX_LEFT
   } mlh_ctx_type;

   typedef enum logic [1:0] {
      SLOT_L = 2'd0,
      SLOT_M = 2'd1,
      SLOT_R = 2'd2
   } mlh_slot_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_RED_START,
      S_LD_RD,
      S_LD_CAP,
      S_RED_EVAL,
      S_CROSS_A,
      S_DIV_A,
      S_CROSS_B,
      S_DIV_B,
      S_RED_CMP,
      S_RED_ACT,
      S_RM_CHK,
      S_RM_WR,
      S_CHK_RIGHT,
      S_CHK_LEFT,
      S_Q_CHK,
      S_V_RD,
      S_V_CAP,
      S_V_MUL,
      S_V_ADD,
      S_Q_CMP,
      S_OUT
   } mlh_state_type;

   typedef struct packed {
      logic           capture;
      logic           ram_we;
      logic           wr_new;
      logic           ld_en;
      mlh_slot_type   ld_slot;
      logic           pair;       // 0: left/middle, 1: middle/right
      logic           div_start;
      logic           cross_ld;
      logic           cross_sent;
      logic           mul;
      logic           val_ld;
      logic           val_idx;
      logic           out_ld;
      logic           out_best;
      mlh_status_type out_status;
   } mlh_cmd_type;

   typedef struct packed {
      logic le_new;
      logic eq_lm;
      logic le_ml;
      logic eq_mr;
      logic le_mr;
      logic red_mid;
      logic val_lt;
      logic div_done;
   } mlh_sts_type;

endpackage

### design/mlh_ram.sv
// ----------------------------------------------------------------------------
// mlh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

### design/mlh_div.sv
// ----------------------------------------------------------------------------
// mlh_div: iterative floor divider
// Signed 64-bit numerator by a positive 32-bit divisor, one quotient bit per
// cycle, then a sign and floor correction step.
// ----------------------------------------------------------------------------
module mlh_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mlh_pkg::VAL_W-1:0]   num,
   input  logic [mlh_pkg::SLOPE_W-1:0]        den,
   output logic                              done,
   output logic signed [mlh_pkg::VAL_W-1:0]   quot
);

   localparam int NW = mlh_pkg::VAL_W;
   localparam int DW = mlh_pkg::SLOPE_W;
   localparam int CNT_W = $clog2(NW);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic signed [NW-1:0] quot_ff, quot_in;
   logic [DW:0]       shifted;
   logic [DW:0]       trial;
   logic [NW-1:0]     mag;

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      quot_in = quot_ff;
      mag     = num[NW-1] ? NW'(-num) : NW'(num);
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[NW-1];
         den_in  = den;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + CNT_W'(1));
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // negative numerator: floor rounds away from zero when inexact
         if (neg_ff) begin
            quot_in = -$signed(quo_ff + NW'(rem_ff != '0));
         end else begin
            quot_in = $signed(quo_ff);
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### design/mlh_datapath.sv
// ----------------------------------------------------------------------------
// mlh_datapath: line table, operand registers and arithmetic
// Holds the line RAM, the three-line window for redundancy tests, the
// intersection divider and the evaluation multiplier.
// ----------------------------------------------------------------------------
module mlh_datapath #(
   parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mlh_pkg::mlh_cmd_type                 cmd,
   output mlh_pkg::mlh_sts_type                 sts,
   input  logic [$clog2(MAX_LINES)-1:0]         rd_addr,
   input  logic [$clog2(MAX_LINES)-1:0]         wr_addr,
   input  logic signed [mlh_pkg::SLOPE_W-1:0]   req_slope,
   input  logic signed [mlh_pkg::ICPT_W-1:0]    req_intercept,
   input  logic signed [mlh_pkg::X_W-1:0]       req_query_x,
   output logic signed [mlh_pkg::VAL_W-1:0]     rsp_best_value,
   output mlh_pkg::mlh_status_type              rsp_status
);

   localparam int SW = mlh_pkg::SLOPE_W;
   localparam int IW = mlh_pkg::ICPT_W;
   localparam int VW = mlh_pkg::VAL_W;
   localparam int LW = mlh_pkg::LINE_W;
   localparam logic signed [VW-1:0] CROSS_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] CROSS_MIN = {1'b1, {(VW-1){1'b0}}};

   logic signed [SW-1:0]  new_slope_ff;
   logic signed [IW-1:0]  new_icpt_ff;
   logic signed [mlh_pkg::X_W-1:0] x_ff;
   logic signed [SW-1:0]  slope_ff [3];
   logic signed [IW-1:0]  icpt_ff [3];
   logic signed [VW-1:0]  cross_ff [2];
   logic signed [VW-1:0]  prod_ff;
   logic signed [VW-1:0]  val_ff [2];
   logic signed [VW-1:0]  best_ff;
   mlh_pkg::mlh_status_type status_ff;

   logic [LW-1:0]         ram_q;
   logic [LW-1:0]         ram_wdata;
   logic signed [SW-1:0]  q_slope;
   logic signed [IW-1:0]  q_icpt;

   logic signed [VW-1:0]  div_num;
   logic signed [SW:0]    slope_diff;
   logic [SW-1:0]         div_den;
   logic                  div_done;
   logic signed [VW-1:0]  div_quot;
   logic signed [VW-1:0]  sentinel;

   assign q_slope   = $signed(ram_q[SW-1:0]);
   assign q_icpt    = $signed(ram_q[LW-1:SW]);
   assign ram_wdata = cmd.wr_new ? {new_icpt_ff, new_slope_ff} : ram_q;

   mlh_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_LINES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (wr_addr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // pair 0 intersects left with middle, pair 1 middle with right
   always_comb begin
      if (cmd.pair) begin
         div_num    = VW'(icpt_ff[1]) - VW'(icpt_ff[2]);
         slope_diff = (SW+1)'(slope_ff[2]) - (SW+1)'(slope_ff[1]);
         sentinel   = (icpt_ff[1] > icpt_ff[2]) ? CROSS_MAX : CROSS_MIN;
      end else begin
         div_num    = VW'(icpt_ff[0]) - VW'(icpt_ff[1]);
         slope_diff = (SW+1)'(slope_ff[1]) - (SW+1)'(slope_ff[0]);
         sentinel   = (icpt_ff[0] > icpt_ff[1]) ? CROSS_MAX : CROSS_MIN;
      end
      div_den = slope_diff[SW-1:0];
   end

   mlh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_slope_ff <= req_slope;
         new_icpt_ff  <= req_intercept;
         x_ff         <= req_query_x;
      end
      if (cmd.ld_en) begin
         slope_ff[cmd.ld_slot] <= q_slope;
         icpt_ff[cmd.ld_slot]  <= q_icpt;
      end
      if (cmd.cross_ld) begin
         cross_ff[cmd.pair] <= cmd.cross_sent ? sentinel : div_quot;
      end
      if (cmd.mul) begin
         prod_ff <= slope_ff[1] * x_ff;
      end
      if (cmd.val_ld) begin
         val_ff[cmd.val_idx] <= prod_ff + VW'(icpt_ff[1]);
      end
      if (cmd.out_ld) begin
         best_ff   <= cmd.out_best ? val_ff[0] : '0;
         status_ff <= cmd.out_status;
      end
   end

   always_comb begin
      sts.le_new   = q_slope <= new_slope_ff;
      sts.eq_lm    = slope_ff[0] == slope_ff[1];
      sts.le_ml    = icpt_ff[1] <= icpt_ff[0];
      sts.eq_mr    = slope_ff[1] == slope_ff[2];
      sts.le_mr    = icpt_ff[1] <= icpt_ff[2];
      sts.red_mid  = cross_ff[0] >= cross_ff[1];
      sts.val_lt   = val_ff[0] < val_ff[1];
      sts.div_done = div_done;
   end

   assign rsp_best_value = best_ff;
   assign rsp_status     = status_ff;

endmodule

### design/mlh_ctrl.sv
// ----------------------------------------------------------------------------
// mlh_ctrl: sequencing controller
// Walks the table for insert position, shifts, redundancy tests, removals
// and the query binary search; owns the line count and all indices.
// ----------------------------------------------------------------------------
module mlh_ctrl #(
   parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_mode,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  mlh_pkg::mlh_sts_type          sts,
   output mlh_pkg::mlh_cmd_type          cmd,
   output logic [$clog2(MAX_LINES)-1:0]  rd_addr,
   output logic [$clog2(MAX_LINES)-1:0]  wr_addr
);

   localparam int AW = $clog2(MAX_LINES);
   localparam int CW = $clog2(MAX_LINES + 1);

   mlh_pkg::mlh_state_type  state_ff, state_in;
   mlh_pkg::mlh_ctx_type    ctx_ff, ctx_in;
   mlh_pkg::mlh_status_type status_ff, status_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [1:0]    j_ff, j_in;
   logic          red_ff, red_in;
   logic          vslot_ff, vslot_in;
   logic          final_ff, final_in;
   logic          mode_ff, mode_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          i_last;
   logic [1:0]    j_last;
   logic          out_free;
   logic [CW-1:0] rd_idx, wr_idx;

   assign i_last   = CW'(i_ff + CW'(1)) >= count_ff;
   assign j_last   = i_last ? 2'd1 : 2'd2;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state and register updates
   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      red_in       = red_ff;
      vslot_in     = vslot_ff;
      final_in     = final_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         mlh_pkg::S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_mode;
               if (!req_mode) begin
                  if (count_ff == CW'(MAX_LINES)) begin
                     status_in = mlh_pkg::ST_FULL;
                     state_in  = mlh_pkg::S_OUT;
                  end else begin
                     k_in     = '0;
                     state_in = mlh_pkg::S_SCAN_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mlh_pkg::ST_EMPTY;
                     state_in  = mlh_pkg::S_OUT;
                  end else begin
                     lo_in    = '0;
                     hi_in    = CW'(count_ff - CW'(1));
                     state_in = mlh_pkg::S_Q_CHK;
                  end
               end
            end
         end
         mlh_pkg::S_SCAN_RD: begin
            if (k_ff == count_ff) begin
               pos_in   = k_ff;
               state_in = mlh_pkg::S_SHIFT_CHK;
            end else begin
               state_in = mlh_pkg::S_SCAN_CHK;
            end
         end
         mlh_pkg::S_SCAN_CHK: begin
            if (sts.le_new) begin
               k_in     = CW'(k_ff + CW'(1));
               state_in = mlh_pkg::S_SCAN_RD;
            end else begin
               pos_in   = k_ff;
               k_in     = count_ff;
               state_in = mlh_pkg::S_SHIFT_CHK;
            end
         end
         mlh_pkg::S_SHIFT_CHK: begin
            if (k_ff == pos_ff) begin
               count_in = CW'(count_ff + CW'(1));
               i_in     = pos_ff;
               ctx_in   = mlh_pkg::CTX_INS;
               state_in = mlh_pkg::S_RED_START;
            end else begin
               state_in = mlh_pkg::S_SHIFT_WR;
            end
         end
         mlh_pkg::S_SHIFT_WR: begin
            k_in     = CW'(k_ff - CW'(1));
            state_in = mlh_pkg::S_SHIFT_CHK;
         end
         mlh_pkg::S_RED_START: begin
            if (i_ff == '0 && count_ff < CW'(2)) begin
               red_in   = 1'b0;
               state_in = mlh_pkg::S_RED_ACT;
            end else begin
               j_in     = (i_ff == '0) ? 2'd1 : 2'd0;
               state_in = mlh_pkg::S_LD_RD;
            end
         end
         mlh_pkg::S_LD_RD: begin
            state_in = mlh_pkg::S_LD_CAP;
         end
         mlh_pkg::S_LD_CAP: begin
            if (j_ff == j_last) begin
               state_in = mlh_pkg::S_RED_EVAL;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = mlh_pkg::S_LD_RD;
            end
         end
         mlh_pkg::S_RED_EVAL: begin
            if (i_ff == '0) begin
               red_in   = sts.eq_mr && sts.le_mr;
               state_in = mlh_pkg::S_RED_ACT;
            end else if (i_last) begin
               red_in   = sts.eq_lm && sts.le_ml;
               state_in = mlh_pkg::S_RED_ACT;
            end else begin
               state_in = mlh_pkg::S_CROSS_A;
            end
         end
         mlh_pkg::S_CROSS_A: begin
            state_in = sts.eq_lm ? mlh_pkg::S_CROSS_B : mlh_pkg::S_DIV_A;
         end
         mlh_pkg::S_DIV_A: begin
            if (sts.div_done) begin
               state_in = mlh_pkg::S_CROSS_B;
            end
         end
         mlh_pkg::S_CROSS_B: begin
            state_in = sts.eq_mr ? mlh_pkg::S_RED_CMP : mlh_pkg::S_DIV_B;
         end
         mlh_pkg::S_DIV_B: begin
            if (sts.div_done) begin
               state_in = mlh_pkg::S_RED_CMP;
            end
         end
         mlh_pkg::S_RED_CMP: begin
            red_in   = sts.red_mid;
            state_in = mlh_pkg::S_RED_ACT;
         end
         mlh_pkg::S_RED_ACT: begin
            if (red_ff) begin
               k_in     = i_ff;
               state_in = mlh_pkg::S_RM_CHK;
            end else begin
               unique case (ctx_ff)
                  mlh_pkg::CTX_INS:   state_in = mlh_pkg::S_CHK_RIGHT;
                  mlh_pkg::CTX_RIGHT: state_in = mlh_pkg::S_CHK_LEFT;
                  default: begin
                     status_in = mlh_pkg::ST_DONE;
                     state_in  = mlh_pkg::S_OUT;
                  end
               endcase
            end
         end
         mlh_pkg::S_RM_CHK: begin
            if (CW'(k_ff + CW'(1)) < count_ff) begin
               state_in = mlh_pkg::S_RM_WR;
            end else begin
               count_in = CW'(count_ff - CW'(1));
               unique case (ctx_ff)
                  mlh_pkg::CTX_INS: begin
                     status_in = mlh_pkg::ST_REDUNDANT;
                     state_in  = mlh_pkg::S_OUT;
                  end
                  mlh_pkg::CTX_RIGHT: state_in = mlh_pkg::S_CHK_RIGHT;
                  default: begin
                     pos_in   = CW'(pos_ff - CW'(1));
                     state_in = mlh_pkg::S_CHK_LEFT;
                  end
               endcase
            end
         end
         mlh_pkg::S_RM_WR: begin
            k_in     = CW'(k_ff + CW'(1));
            state_in = mlh_pkg::S_RM_CHK;
         end
         mlh_pkg::S_CHK_RIGHT: begin
            ctx_in = mlh_pkg::CTX_RIGHT;
            if (CW'(pos_ff + CW'(1)) < count_ff) begin
               i_in     = CW'(pos_ff + CW'(1));
               state_in = mlh_pkg::S_RED_START;
            end else begin
               state_in = mlh_pkg::S_CHK_LEFT;
            end
         end
         mlh_pkg::S_CHK_LEFT: begin
            ctx_in = mlh_pkg::CTX_LEFT;
            if (pos_ff != '0) begin
               i_in     = CW'(pos_ff - CW'(1));
               state_in = mlh_pkg::S_RED_START;
            end else begin
               status_in = mlh_pkg::ST_DONE;
               state_in  = mlh_pkg::S_OUT;
            end
         end
         mlh_pkg::S_Q_CHK: begin
            vslot_in = 1'b0;
            if (lo_ff < hi_ff) begin
               k_in     = CW'(lo_ff + ((hi_ff - lo_ff) >> 1));
               final_in = 1'b0;
            end else begin
               k_in     = lo_ff;
               final_in = 1'b1;
            end
            state_in = mlh_pkg::S_V_RD;
         end
         mlh_pkg::S_V_RD:  state_in = mlh_pkg::S_V_CAP;
         mlh_pkg::S_V_CAP: state_in = mlh_pkg::S_V_MUL;
         mlh_pkg::S_V_MUL: state_in = mlh_pkg::S_V_ADD;
         mlh_pkg::S_V_ADD: begin
            if (final_ff) begin
               status_in = mlh_pkg::ST_DONE;
               state_in  = mlh_pkg::S_OUT;
            end else if (!vslot_ff) begin
               vslot_in = 1'b1;
               k_in     = CW'(k_ff + CW'(1));
               state_in = mlh_pkg::S_V_RD;
            end else begin
               state_in = mlh_pkg::S_Q_CMP;
            end
         end
         mlh_pkg::S_Q_CMP: begin
            // k holds mid + 1 here
            if (sts.val_lt) begin
               lo_in = k_ff;
            end else begin
               hi_in = CW'(k_ff - CW'(1));
            end
            state_in = mlh_pkg::S_Q_CHK;
         end
         mlh_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = mlh_pkg::S_IDLE;
            end
         end
         default: state_in = mlh_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd            = '0;
      cmd.ld_slot    = mlh_pkg::SLOT_L;
      cmd.out_status = status_ff;
      rd_idx         = k_ff;
      wr_idx         = k_ff;
      unique case (state_ff)
         mlh_pkg::S_IDLE: begin
            cmd.capture = req_tvalid;
         end
         mlh_pkg::S_SHIFT_CHK: begin
            if (k_ff == pos_ff) begin
               cmd.ram_we = 1'b1;
               cmd.wr_new = 1'b1;
               wr_idx     = pos_ff;
            end else begin
               rd_idx = CW'(k_ff - CW'(1));
            end
         end
         mlh_pkg::S_SHIFT_WR: begin
            cmd.ram_we = 1'b1;
         end
         mlh_pkg::S_LD_RD: begin
            rd_idx = CW'(i_ff + CW'(j_ff) - CW'(1));
         end
         mlh_pkg::S_LD_CAP: begin
            cmd.ld_en   = 1'b1;
            cmd.ld_slot = mlh_pkg::mlh_slot_type'(j_ff);
         end
         mlh_pkg::S_CROSS_A: begin
            cmd.cross_ld   = sts.eq_lm;
            cmd.cross_sent = 1'b1;
            cmd.div_start  = !sts.eq_lm;
         end
         mlh_pkg::S_DIV_A: begin
            cmd.cross_ld = sts.div_done;
         end
         mlh_pkg::S_CROSS_B: begin
            cmd.pair       = 1'b1;
            cmd.cross_ld   = sts.eq_mr;
            cmd.cross_sent = 1'b1;
            cmd.div_start  = !sts.eq_mr;
         end
         mlh_pkg::S_DIV_B: begin
            cmd.pair     = 1'b1;
            cmd.cross_ld = sts.div_done;
         end
         mlh_pkg::S_RM_CHK: begin
            rd_idx = CW'(k_ff + CW'(1));
         end
         mlh_pkg::S_RM_WR: begin
            cmd.ram_we = 1'b1;
         end
         mlh_pkg::S_V_CAP: begin
            cmd.ld_en   = 1'b1;
            cmd.ld_slot = mlh_pkg::SLOT_M;
         end
         mlh_pkg::S_V_MUL: begin
            cmd.mul = 1'b1;
         end
         mlh_pkg::S_V_ADD: begin
            cmd.val_ld  = 1'b1;
            cmd.val_idx = vslot_ff;
         end
         mlh_pkg::S_OUT: begin
            cmd.out_ld   = out_free;
            cmd.out_best = mode_ff && (status_ff == mlh_pkg::ST_DONE);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlh_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ctx_ff    <= ctx_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      j_ff      <= j_in;
      red_ff    <= red_in;
      vslot_ff  <= vslot_in;
      final_ff  <= final_in;
      mode_ff   <= mode_in;
   end

   assign req_tready = state_ff == mlh_pkg::S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rd_addr    = rd_idx[AW-1:0];
   assign wr_addr    = wr_idx[AW-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LINES))
      else $error("line count above table size");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> wr_idx <= count_ff)
      else $error("table write beyond kept lines");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == mlh_pkg::S_OUT)
      else $error("result raised outside output state");

   a_full_no_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlh_pkg::S_SCAN_RD) |-> count_ff < CW'(MAX_LINES))
      else $error("insert started on a full table");

endmodule

### design/max_line_hull_engine.sv
// ----------------------------------------------------------------------------
// max_line_hull_engine: upper envelope of lines with maximum queries
// Keeps lines y = slope*x + intercept sorted by slope, drops dominated lines
// on insert and answers the maximum at a point by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per command. tuser selects insert (0) or
//   query (1); tdata carries slope, intercept and query_x.
//   rsp channel: exactly one transfer per command, best_value in tdata and
//   the status code in tuser (done, redundant, table full, empty).
//   An insert scans for its place line by line, shifts the lines above it,
//   runs redundancy tests with up to two serial divisions each and moves
//   lines on each removal; a query evaluates two lines per binary search
//   step and one more line at the end. The serial divider and the single
//   RAM port bound the speed.
//   One command is processed at a time; the next is taken once the previous
//   result sits in the output register, even if it has not been taken yet.
//   Reset empties the table at once; there is no clearing pass.
//   A stalled rsp holds its result; processing stops before the next result
//   until the output register is free.
// ----------------------------------------------------------------------------
module max_line_hull_engine #(
   parameter int MAX_LINES = mlh_pkg::MAX_LINES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slope [31:0], intercept [94:32], query_x [126:95], zero [127]
   input  logic [mlh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode [0]
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // best_value [63:0]
   output logic [mlh_pkg::VAL_W-1:0]          rsp_tdata,
   // status [1:0]
   output logic [1:0]                         rsp_tuser
);

   localparam int AW = $clog2(MAX_LINES);
   localparam int SW = mlh_pkg::SLOPE_W;
   localparam int IW = mlh_pkg::ICPT_W;
   localparam int XW = mlh_pkg::X_W;

   mlh_pkg::mlh_cmd_type    cmd;
   mlh_pkg::mlh_sts_type    sts;
   mlh_pkg::mlh_status_type status;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic signed [mlh_pkg::VAL_W-1:0] best_value;

   mlh_ctrl #(
      .MAX_LINES (MAX_LINES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   mlh_datapath #(
      .MAX_LINES (MAX_LINES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .req_slope      ($signed(req_tdata[SW-1:0])),
      .req_intercept  ($signed(req_tdata[SW+IW-1:SW])),
      .req_query_x    ($signed(req_tdata[SW+IW+XW-1:SW+IW])),
      .rsp_best_value (best_value),
      .rsp_status     (status)
   );

   assign rsp_tdata = best_value;
   assign rsp_tuser = status;

endmodule

### verif/max_line_hull_engine_test.sv
// ----------------------------------------------------------------------------
// max_line_hull_engine_test: self-checking bench for the line hull engine
// A short table of directed commands is followed by random inserts and
// queries, checked against a behavioural hull kept in the bench. The bench
// then fills the table to capacity. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module max_line_hull_engine_test;

   localparam int       LINES      = mlh_pkg::MAX_LINES_DEF;
   localparam int       N_RANDOM   = 340;
   localparam int       HOLD_LEN   = 3000;
   localparam int       DRAIN_WAIT = 400;
   localparam longint   CYCLE_CAP  = 4000000;
   localparam bit       OP_INSERT  = 1'b0;
   localparam bit       OP_QUERY   = 1'b1;
   localparam longint   VAL_HI     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint   VAL_LO     = 64'sh8000_0000_0000_0000;

   typedef struct {
      bit                      mode;
      logic [31:0]             slope;
      logic [62:0]             icpt;
      logic [31:0]             qx;
      bit                      typed;     // expected value given in the row
      logic [63:0]             val;
      mlh_pkg::mlh_status_type st;
   } cmd_row_type;

   typedef struct {
      logic [63:0]             val;
      mlh_pkg::mlh_status_type st;
   } hull_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [127:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   max_line_hull_engine dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // behavioural hull, sorted by slope
   longint          hull_slope [LINES+1];
   longint          hull_icpt  [LINES+1];
   int              hull_count = 0;
   hull_answer_type answers_due[$];
   int              mismatches = 0;
   int              n_ins = 0, n_qry = 0, n_red = 0, n_full = 0, n_empty = 0;
   longint          cycles = 0;
   bit              hold_req = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0)))
         q = q - 1;
      return q;
   endfunction

   // floor of the x where line b overtakes line a
   function automatic longint cross_x(int a, int b);
      if (hull_slope[a] == hull_slope[b])
         return (hull_icpt[a] > hull_icpt[b]) ? VAL_HI : VAL_LO;
      return floor_quot(hull_icpt[a] - hull_icpt[b], hull_slope[b] - hull_slope[a]);
   endfunction

   function automatic bit line_dominated(int i);
      if (i == 0) begin
         if (hull_count < 2)
            return 1'b0;
         return hull_slope[0] == hull_slope[1] && hull_icpt[0] <= hull_icpt[1];
      end
      if (i + 1 >= hull_count)
         return hull_slope[i] == hull_slope[i-1] && hull_icpt[i] <= hull_icpt[i-1];
      return cross_x(i - 1, i) >= cross_x(i, i + 1);
   endfunction

   function automatic void drop_line(int i);
      for (int k = i; k + 1 < hull_count; k++) begin
         hull_slope[k] = hull_slope[k+1];
         hull_icpt[k]  = hull_icpt[k+1];
      end
      hull_count--;
   endfunction

   function automatic longint line_at(int i, longint x);
      return hull_slope[i] * x + hull_icpt[i];
   endfunction

   function automatic hull_answer_type hull_apply(bit mode, logic [31:0] slope,
                                                  logic [62:0] icpt, logic [31:0] qx);
      hull_answer_type r;
      longint m, b, x;
      int pos, lo, hi, mid;
      r.val = '0;
      r.st  = mlh_pkg::ST_DONE;
      if (mode == OP_INSERT) begin
         m = longint'($signed(slope));
         b = longint'($signed(icpt));
         if (hull_count >= LINES) begin
            r.st = mlh_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < hull_count && hull_slope[pos] <= m)
               pos++;
            for (int k = hull_count; k > pos; k--) begin
               hull_slope[k] = hull_slope[k-1];
               hull_icpt[k]  = hull_icpt[k-1];
            end
            hull_slope[pos] = m;
            hull_icpt[pos]  = b;
            hull_count++;
            if (line_dominated(pos)) begin
               drop_line(pos);
               r.st = mlh_pkg::ST_REDUNDANT;
            end else begin
               while (pos + 1 < hull_count && line_dominated(pos + 1))
                  drop_line(pos + 1);
               while (pos > 0 && line_dominated(pos - 1)) begin
                  drop_line(pos - 1);
                  pos--;
               end
            end
         end
      end else begin
         x = longint'($signed(qx));
         if (hull_count == 0) begin
            r.st = mlh_pkg::ST_EMPTY;
         end else begin
            lo = 0;
            hi = hull_count - 1;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (line_at(mid, x) < line_at(mid + 1, x))
                  lo = mid + 1;
               else
                  hi = mid;
            end
            r.val = line_at(lo, x);
         end
      end
      return r;
   endfunction

   // one command transfer; valid stays high into the next command
   task automatic issue_cmd(cmd_row_type c);
      hull_answer_type a;
      req_tvalid <= 1'b1;
      req_tuser  <= c.mode;
      req_tdata  <= {1'b0, c.qx, c.icpt, c.slope};
      do @(posedge clock); while (!req_tready);
      a = hull_apply(c.mode, c.slope, c.icpt, c.qx);
      if (c.typed) begin
         a.val = c.val;
         a.st  = c.st;
      end
      answers_due.push_back(a);
      if (c.mode == OP_INSERT) n_ins++; else n_qry++;
   endtask

   int burst_left = 0;

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [62:0] pick_icpt(bit wide);
      if (wide)
         return 63'({$urandom, $urandom});
      return 63'($signed(32'($urandom_range(0, 20000)) - 32'sd10000));
   endfunction

   function automatic cmd_row_type random_cmd();
      cmd_row_type c;
      c.typed = 1'b0;
      c.val   = '0;
      c.st    = mlh_pkg::ST_DONE;
      c.mode  = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
      if ($urandom_range(0, 4) == 0) begin
         c.slope = $urandom;
         c.icpt  = pick_icpt(1'b1);
         c.qx    = $urandom;
      end else begin
         c.slope = 32'($signed($urandom_range(0, 200)) - 100);
         c.icpt  = pick_icpt(1'b0);
         c.qx    = 32'($signed($urandom_range(0, 2000)) - 1000);
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
   endtask

   // result side: monitor and scoreboard
   always @(posedge clock) begin
      hull_answer_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result with nothing expected", 64'd0, rsp_tdata);
         end else begin
            e = answers_due.pop_front();
            if (rsp_tdata !== e.val)
               report_mismatch("best_value", e.val, rsp_tdata);
            if (rsp_tuser !== e.st)
               report_mismatch("status", 64'(e.st), 64'(rsp_tuser));
            case (e.st)
               mlh_pkg::ST_REDUNDANT: n_red++;
               mlh_pkg::ST_FULL:      n_full++;
               mlh_pkg::ST_EMPTY:     n_empty++;
               default: ;
            endcase
         end
      end
   end

   // receiver: changing stall pattern, plus one long hold on request
   initial begin
      int mode_left;
      int rx_mode;
      mode_left = 0;
      rx_mode   = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(16, 128);
               rx_mode   = $urandom_range(0, 2);
            end
            mode_left--;
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      cmd_row_type dir_tab[$];
      cmd_row_type c;
      int tries;
      dir_tab = '{
         '{OP_QUERY,  32'd0, 63'd0, 32'd0, 1'b1, 64'd0, mlh_pkg::ST_EMPTY},
         '{OP_INSERT, 32'd0, 63'd5, 32'hFFFF_FFFF, 1'b1, 64'd0, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'd0, 63'd3, 32'd0, 1'b1, 64'd0, mlh_pkg::ST_REDUNDANT},
         '{OP_INSERT, 32'd0, 63'd5, 32'd0, 1'b1, 64'd0, mlh_pkg::ST_REDUNDANT},
         '{OP_QUERY,  32'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0,
           1'b1, 64'd5, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'd0, 63'd9, 32'd0, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'h7FFF_FFFF, 63'h3FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'h8000_0000, 63'h4000_0000_0000_0000, 32'd0, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'd0, 63'd0, 32'h7FFF_FFFF, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'd0, 63'd0, 32'h8000_0000, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'd0, 63'd0, 32'hFFFF_FFFF, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'h7FFF_FFFF, 63'h3FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'd1, 63'd0, 32'd0, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'd2, 63'h7FFF_FFFF_FFFF_FFFE, 32'd0, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'd3, 63'h7FFF_FFFF_FFFF_FFFC, 32'd0, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'hFFFF_FFFF, 63'd7, 32'd0, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_INSERT, 32'hFFFF_FFFE, 63'd7, 32'd0, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'h1234_5678, 63'h5555_5555_5555_5555, 32'd1, 1'b0, 64'd0,
           mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'd0, 63'd0, 32'hFFFF_FFF0, 1'b0, 64'd0, mlh_pkg::ST_DONE},
         '{OP_QUERY,  32'd0, 63'd0, 32'h0000_0100, 1'b0, 64'd0, mlh_pkg::ST_DONE}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         issue_cmd(dir_tab[i]);
      wait_drained();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 120)
            hold_req = 1'b1;
         if (n == 240)
            wait_drained();
         issue_cmd(random_cmd());
         pace_sender();
      end
      wait_drained();

      // tangents of a parabola: each stays on the hull until the table is full
      tries = 1;
      while (hull_count < LINES && tries < 200) begin
         longint t;
         t = -64'sd1073741824 + 64'(tries) * 64;
         c = random_cmd();
         c.mode  = OP_INSERT;
         c.slope = 32'(2 * t);
         c.icpt  = 63'(-(t * t));
         issue_cmd(c);
         pace_sender();
         tries++;
      end
      for (int n = 0; n < 12; n++) begin
         issue_cmd(random_cmd());
         pace_sender();
      end
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d inserts and %0d queries: %0d redundant, %0d full, %0d empty",
               n_ins, n_qry, n_red, n_full, n_empty);
      $display("hull held %0d lines at the end, %0d mismatches", hull_count, mismatches);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
